// File: design/hdf_pkg.sv
`timescale 1ns / 1ps

package hdf_pkg;

   // Line geometry and fixed characters
   localparam logic [4:0] LINE_LEN     = 5'd16;
   localparam logic [4:0] LINE_HALF    = 5'd8;
   localparam logic [5:0] ASCII_COLUMN = 6'd51;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0d;
   localparam logic [7:0] CH_LF        = 8'h0a;
   localparam logic [7:0] CH_DOT       = 8'h2e;
   localparam logic [7:0] CH_PRINT_LO  = 8'h20;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7e;

   // Format flag bits
   localparam int FLAG_ASCII = 0;
   localparam int FLAG_ADDR  = 1;

   // Microprogram step addresses
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_ADDR_CHK = 4'd1;
   localparam logic [3:0] ST_ADDR     = 4'd2;
   localparam logic [3:0] ST_TAB      = 4'd3;
   localparam logic [3:0] ST_SEP      = 4'd4;
   localparam logic [3:0] ST_SEP2     = 4'd5;
   localparam logic [3:0] ST_HI       = 4'd6;
   localparam logic [3:0] ST_LO       = 4'd7;
   localparam logic [3:0] ST_ASC_CHK  = 4'd8;
   localparam logic [3:0] ST_PAD      = 4'd9;
   localparam logic [3:0] ST_ASC      = 4'd10;
   localparam logic [3:0] ST_CR       = 4'd11;
   localparam logic [3:0] ST_LF       = 4'd12;

   // Character source of one step
   typedef enum logic [2:0] {
      CS_SPACE,
      CS_TAB,
      CS_CR,
      CS_LF,
      CS_ADDR_DIG,
      CS_HEX_HI,
      CS_HEX_LO,
      CS_ASCII
   } char_sel_type;

   // Branch condition of one step: jump to target when true, else fall through
   typedef enum logic [3:0] {
      CN_NEXT,
      CN_JUMP,
      CN_LINE_MID,
      CN_NO_ADDR,
      CN_LOOP,
      CN_NOT_MID,
      CN_NOT_EOL,
      CN_NO_ASCII,
      CN_MORE_ASCII
   } cond_type;

   typedef struct packed {
      logic         wait_req;
      logic         emit;
      char_sel_type sel;
      cond_type     cond;
      logic [3:0]   target;
      logic         ld_digits;
      logic         ld_pad;
      logic         dec_loop;
      logic         clr_idx;
      logic         inc_idx;
      logic         commit;
      logic         line_end;
   } ctrl_word_type;

   // Datapath status seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic out_blocked;
      logic line_mid;
      logic mid8;
      logic addr_en;
      logic eol;
      logic ascii_en;
      logic loop_nz;
      logic more_ascii;
   } seq_flags_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      begin
         if (nib < 4'd10) begin
            c = 8'h30 + {4'd0, nib};
         end else begin
            c = 8'h57 + {4'd0, nib};
         end
         return c;
      end
   endfunction

   // Control store
   function automatic ctrl_word_type ucode(input logic [3:0] addr);
      ctrl_word_type w;
      begin
         w = '0;
         case (addr)
            ST_IDLE: begin
               w.wait_req = 1'b1;
               w.cond     = CN_LINE_MID;
               w.target   = ST_SEP;
            end
            ST_ADDR_CHK: begin
               w.ld_digits = 1'b1;
               w.cond      = CN_NO_ADDR;
               w.target    = ST_HI;
            end
            ST_ADDR: begin
               w.emit     = 1'b1;
               w.sel      = CS_ADDR_DIG;
               w.dec_loop = 1'b1;
               w.cond     = CN_LOOP;
               w.target   = ST_ADDR;
            end
            ST_TAB: begin
               w.emit   = 1'b1;
               w.sel    = CS_TAB;
               w.cond   = CN_JUMP;
               w.target = ST_HI;
            end
            ST_SEP: begin
               w.emit   = 1'b1;
               w.sel    = CS_SPACE;
               w.cond   = CN_NOT_MID;
               w.target = ST_HI;
            end
            ST_SEP2: begin
               w.emit = 1'b1;
               w.sel  = CS_SPACE;
            end
            ST_HI: begin
               w.emit = 1'b1;
               w.sel  = CS_HEX_HI;
            end
            ST_LO: begin
               w.emit   = 1'b1;
               w.sel    = CS_HEX_LO;
               w.commit = 1'b1;
               w.cond   = CN_NOT_EOL;
               w.target = ST_IDLE;
            end
            ST_ASC_CHK: begin
               w.ld_pad  = 1'b1;
               w.clr_idx = 1'b1;
               w.cond    = CN_NO_ASCII;
               w.target  = ST_CR;
            end
            ST_PAD: begin
               w.emit     = 1'b1;
               w.sel      = CS_SPACE;
               w.dec_loop = 1'b1;
               w.cond     = CN_LOOP;
               w.target   = ST_PAD;
            end
            ST_ASC: begin
               w.emit    = 1'b1;
               w.sel     = CS_ASCII;
               w.inc_idx = 1'b1;
               w.cond    = CN_MORE_ASCII;
               w.target  = ST_ASC;
            end
            ST_CR: begin
               w.emit = 1'b1;
               w.sel  = CS_CR;
            end
            ST_LF: begin
               w.emit     = 1'b1;
               w.sel      = CS_LF;
               w.line_end = 1'b1;
               w.cond     = CN_JUMP;
               w.target   = ST_IDLE;
            end
            default: begin
               w.cond   = CN_JUMP;
               w.target = ST_IDLE;
            end
         endcase
         return w;
      end
   endfunction

endpackage

// File: design/hdf_useq.sv
`timescale 1ns / 1ps

module hdf_useq (
   input  logic                   clock,
   input  logic                   reset,
   input  hdf_pkg::seq_flags_type flags,
   output hdf_pkg::ctrl_word_type ucw,
   output logic                   advance
);

   logic [3:0] upc_ff;
   logic [3:0] upc_in;
   logic       taken;

   // Fetch the control word of the current step
   assign ucw = hdf_pkg::ucode(upc_ff);

   // Hold on a blocked output or while waiting for a request
   assign advance = !(ucw.emit && flags.out_blocked) && !(ucw.wait_req && !flags.req_valid);

   // Evaluate the branch condition
   always_comb begin
      case (ucw.cond)
         hdf_pkg::CN_NEXT:       taken = 1'b0;
         hdf_pkg::CN_JUMP:       taken = 1'b1;
         hdf_pkg::CN_LINE_MID:   taken = flags.line_mid;
         hdf_pkg::CN_NO_ADDR:    taken = !flags.addr_en;
         hdf_pkg::CN_LOOP:       taken = flags.loop_nz;
         hdf_pkg::CN_NOT_MID:    taken = !flags.mid8;
         hdf_pkg::CN_NOT_EOL:    taken = !flags.eol;
         hdf_pkg::CN_NO_ASCII:   taken = !flags.ascii_en;
         hdf_pkg::CN_MORE_ASCII: taken = flags.more_ascii;
         default:                taken = 1'b0;
      endcase
   end

   // Select the next step
   always_comb begin
      if (!advance) begin
         upc_in = upc_ff;
      end else if (taken) begin
         upc_in = ucw.target;
      end else begin
         upc_in = upc_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= hdf_pkg::ST_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// File: design/hex_dump_formatter_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                                          Direction
// req       req_valid/req_ready, req_data_byte, req_end_of_data   in
// rsp       rsp_valid/rsp_ready, rsp_text_char, rsp_run_last,     out
//           rsp_dump_done
// csr       csr_wr_en, csr_wr_data (format flags)                 in
//
// A microprogram emits one text character per cycle into a single output
// register. A byte in mid-line emits a space and its two hex digits (two
// spaces after the eighth byte); a line start with the prefix on first emits
// the address digits and a tab. A line end emits pad and the ASCII column if
// on, then CR and LF. The sequencer holds while rsp is stalled.
// Synchronous active-high reset clears the step counter, count and offset.

module hex_dump_formatter_unit #(
   parameter int OFFSET_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_text_char,
   output logic       rsp_run_last,
   output logic       rsp_dump_done,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   hdf_pkg::ctrl_word_type ucw;
   hdf_pkg::seq_flags_type flags;
   logic                   advance;
   logic                   req_accept;

   logic [1:0]             flags_ff;
   logic [7:0]             byte_ff;
   logic                   last_ff;
   logic [4:0]             count_ff;
   logic [4:0]             count_in;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [OFFSET_BITS-1:0] offset_in;
   logic [5:0]             loop_ff;
   logic [5:0]             loop_in;
   logic [3:0]             idx_ff;
   logic [3:0]             idx_in;
   logic [7:0]             line_buf [16];

   logic                   rsp_valid_ff;
   logic [7:0]             rsp_char_ff;
   logic                   rsp_run_last_ff;
   logic                   rsp_dump_done_ff;

   logic [31:0]            addr_ext;
   logic [2:0]             top_nib;
   logic [5:0]             digits_m1;
   logic [5:0]             k6;
   logic [5:0]             hexw;
   logic [5:0]             pad_m1;
   logic [7:0]             buf_char;
   logic [7:0]             char_out;
   logic                   run_last_out;
   logic                   emit_go;

   hdf_useq u_useq (
      .clock   (clock),
      .reset   (reset),
      .flags   (flags),
      .ucw     (ucw),
      .advance (advance)
   );

   assign req_ready  = ucw.wait_req;
   assign req_accept = req_valid && req_ready;
   assign emit_go    = advance && ucw.emit;

   // Status for branch decisions
   always_comb begin
      flags.req_valid   = req_valid;
      flags.out_blocked = rsp_valid_ff && !rsp_ready;
      flags.line_mid    = count_ff != 5'd0;
      flags.mid8        = count_ff == hdf_pkg::LINE_HALF;
      flags.addr_en     = flags_ff[hdf_pkg::FLAG_ADDR];
      flags.eol         = (count_ff == hdf_pkg::LINE_LEN - 5'd1) || last_ff;
      flags.ascii_en    = flags_ff[hdf_pkg::FLAG_ASCII];
      flags.loop_nz     = loop_ff != 6'd0;
      flags.more_ascii  = ({1'b0, idx_ff} + 5'd1) != count_ff;
   end

   // Find the highest nonzero address nibble, at least four digits
   assign addr_ext = 32'(offset_ff);
   always_comb begin
      top_nib = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (addr_ext[4*i +: 4] != 4'd0) begin
            top_nib = 3'(i);
         end
      end
      digits_m1 = (top_nib < 3'd3) ? 6'd3 : {3'd0, top_nib};
   end

   // Pad length to the ASCII column, less one
   always_comb begin
      k6     = {1'b0, count_ff};
      hexw   = (k6 << 1) + k6 - 6'd1 + {5'd0, count_ff > hdf_pkg::LINE_HALF};
      pad_m1 = (hdf_pkg::ASCII_COLUMN - 6'd1) - hexw;
   end

   // Pick the character of the current step
   always_comb begin
      buf_char = line_buf[idx_ff];
      case (ucw.sel)
         hdf_pkg::CS_SPACE:    char_out = hdf_pkg::CH_SPACE;
         hdf_pkg::CS_TAB:      char_out = hdf_pkg::CH_TAB;
         hdf_pkg::CS_CR:       char_out = hdf_pkg::CH_CR;
         hdf_pkg::CS_LF:       char_out = hdf_pkg::CH_LF;
         hdf_pkg::CS_ADDR_DIG: char_out = hdf_pkg::hex_char(addr_ext[4*loop_ff[2:0] +: 4]);
         hdf_pkg::CS_HEX_HI:   char_out = hdf_pkg::hex_char(byte_ff[7:4]);
         hdf_pkg::CS_HEX_LO:   char_out = hdf_pkg::hex_char(byte_ff[3:0]);
         hdf_pkg::CS_ASCII: begin
            if (buf_char >= hdf_pkg::CH_PRINT_LO && buf_char <= hdf_pkg::CH_PRINT_HI) begin
               char_out = buf_char;
            end else begin
               char_out = hdf_pkg::CH_DOT;
            end
         end
         default:              char_out = hdf_pkg::CH_SPACE;
      endcase
      run_last_out = ucw.line_end || (ucw.commit && !flags.eol);
   end

   // Next values of counters and offset
   always_comb begin
      count_in  = count_ff;
      offset_in = offset_ff;
      loop_in   = loop_ff;
      idx_in    = idx_ff;
      if (advance) begin
         if (ucw.commit) begin
            count_in  = count_ff + 5'd1;
            offset_in = offset_ff + OFFSET_BITS'(1);
         end
         if (ucw.line_end) begin
            count_in = 5'd0;
            if (last_ff) begin
               offset_in = '0;
            end
         end
         if (ucw.ld_digits) begin
            loop_in = digits_m1;
         end else if (ucw.ld_pad) begin
            loop_in = pad_m1;
         end else if (ucw.dec_loop && loop_ff != 6'd0) begin
            loop_in = loop_ff - 6'd1;
         end
         if (ucw.clr_idx) begin
            idx_in = 4'd0;
         end else if (ucw.inc_idx) begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= 2'd0;
         count_ff     <= 5'd0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            flags_ff <= csr_wr_data;
         end
         count_ff  <= count_in;
         offset_ff <= offset_in;
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload, loop counter and line buffer
   always_ff @(posedge clock) begin
      loop_ff <= loop_in;
      idx_ff  <= idx_in;
      if (req_accept) begin
         byte_ff <= req_data_byte;
         last_ff <= req_end_of_data;
      end
      if (advance && ucw.commit) begin
         line_buf[count_ff[3:0]] <= byte_ff;
      end
      if (emit_go) begin
         rsp_char_ff      <= char_out;
         rsp_run_last_ff  <= run_last_out;
         rsp_dump_done_ff <= ucw.line_end && last_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_run_last  = rsp_run_last_ff;
   assign rsp_dump_done = rsp_dump_done_ff;

`ifndef SYNTHESIS
   a_idle_count : assert property (@(posedge clock) disable iff (reset)
      req_ready |-> count_ff < hdf_pkg::LINE_LEN)
      else $error("line count full while waiting for a byte");

   a_leave_idle : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("sequencer did not start on an accepted byte");

   a_done_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dump_done_ff |-> rsp_run_last_ff)
      else $error("dump end without end of byte run");
`endif

endmodule
